FILE: design/clr_pkg.sv
// clr_pkg: character codes, result status codes, pending line-end codes and the result beat type
// for the config line reader. no dependencies.
`default_nettype none
package clr_pkg;

	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic [1:0] ST_LINE_END  = 2'd0;
	localparam logic [1:0] ST_END_INPUT = 2'd1;
	localparam logic [1:0] ST_TOO_LONG  = 2'd2;

	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_CR   = 2'd1;
	localparam logic [1:0] PEND_LF   = 2'd2;

	typedef struct packed {
		logic [7:0]  out_char;
		logic        char_valid;
		logic        last;
		logic [1:0]  status;
		logic [31:0] line_number;
	} out_beat_t;

endpackage
`default_nettype wire

FILE: design/clr_in_if.sv
// clr_in_if: input channel of the config line reader, one raw byte or an
// end-of-input mark per beat. no dependencies.
`default_nettype none
interface clr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_input;

	modport source (output valid, output in_char, output end_of_input, input ready);
	modport sink (input valid, input in_char, input end_of_input, output ready);
endinterface
`default_nettype wire

FILE: design/clr_out_if.sv
// clr_out_if: result channel of the config line reader, at most one character
// of a finished line per beat. no dependencies.
`default_nettype none
interface clr_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_char;
	logic        char_valid;
	logic        last;
	logic [1:0]  status;
	logic [31:0] line_number;

	modport source (output valid, output out_char, output char_valid, output last,
		output status, output line_number, input ready);
	modport sink (input valid, input out_char, input char_valid, input last,
		input status, input line_number, output ready);
endinterface
`default_nettype wire

FILE: design/clr_store.sv
// clr_store: line store, one write port and one registered read port.
// no dependencies.
`default_nettype none
module clr_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data_q
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read every cycle, data is discarded where the sequencer does not need it
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

FILE: design/clr_out_reg.sv
// clr_out_reg: output register that holds one result beat until taken.
// depends on clr_pkg and clr_out_if.
`default_nettype none
module clr_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire clr_pkg::out_beat_t beat,
	output logic                   can_load,
	clr_out_if.source              line_out
);

	logic               valid_q;
	clr_pkg::out_beat_t beat_q;

	assign can_load = !valid_q || line_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			beat_q <= beat;
		end
	end

	assign line_out.valid       = valid_q;
	assign line_out.out_char    = beat_q.out_char;
	assign line_out.char_valid  = beat_q.char_valid;
	assign line_out.last        = beat_q.last;
	assign line_out.status      = beat_q.status;
	assign line_out.line_number = beat_q.line_number;

endmodule
`default_nettype wire

FILE: design/config_line_reader_top.sv
// config_line_reader_top: assembles logical lines from a byte stream, one byte per beat.
// a stored or dropped byte is taken in idle; an overflowing byte sends a too-long beat and
// stops the block until end of input. a line end checks a trailing backslash on a non-empty
// line (end of input skips the check), trims trailing blanks one at a time, then sends the
// result beats, each held until taken. input is not ready until the block is back in idle.
// reset clears control state and the line counter, not the line store. uses clr_pkg, clr_in_if,
// clr_out_if, clr_store and clr_out_reg.
`default_nettype none
module config_line_reader_top #(
	parameter int LINE_LEN = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	clr_in_if.sink    stream_in,
	clr_out_if.source line_out
);

	localparam int CW = $clog2(LINE_LEN);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_TRIM  = 3'd2;
	localparam logic [2:0] S_EMIT  = 3'd3;
	localparam logic [2:0] S_ERR   = 3'd4;

	localparam logic [CW:0] FULL_AT = (CW+1)'(LINE_LEN - 2);

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] pos_q, pos_d;
	logic          comment_q, comment_d;
	logic          prev_slash_q, prev_slash_d;
	logic [1:0]    pend_q, pend_d;
	logic [31:0]   counter_q, counter_d;
	logic          stopped_q, stopped_d;
	logic [1:0]    status_q, status_d;

	logic          acc;
	logic [7:0]    c;
	logic          do_store;
	logic          wr_en;
	logic [CW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic          can_load;
	logic          load;
	logic          emit_last;
	clr_pkg::out_beat_t beat;

	assign stream_in.ready = (state_q == S_IDLE);
	assign acc = stream_in.valid && stream_in.ready;
	assign c   = stream_in.in_char;

	assign emit_last = (idx_q == '0) || (pos_q + CW'(1) == idx_q);

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		idx_d        = idx_q;
		pos_d        = pos_q;
		comment_d    = comment_q;
		prev_slash_d = prev_slash_q;
		pend_d       = pend_q;
		counter_d    = counter_q;
		stopped_d    = stopped_q;
		status_d     = status_q;
		do_store     = 1'b0;
		wr_en        = 1'b0;
		load         = 1'b0;
		rd_addr      = count_q - CW'(1);
		beat         = '{out_char: 8'h00, char_valid: 1'b0, last: 1'b1,
			status: status_q, line_number: counter_q};

		case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (stream_in.end_of_input) begin
						pend_d    = clr_pkg::PEND_NONE;
						stopped_d = 1'b0;
						if (!stopped_q) begin
							status_d = clr_pkg::ST_END_INPUT;
							idx_d    = count_q;
							state_d  = S_TRIM;
						end else begin
							count_d      = '0;
							comment_d    = 1'b0;
							prev_slash_d = 1'b0;
						end
					end else if (stopped_q) begin
						// bytes are dropped until end of input
					end else if ((pend_q == clr_pkg::PEND_CR && c == clr_pkg::CH_LF) ||
						(pend_q == clr_pkg::PEND_LF && c == clr_pkg::CH_CR)) begin
						pend_d = clr_pkg::PEND_NONE;
					end else begin
						pend_d = clr_pkg::PEND_NONE;
						if (c == clr_pkg::CH_LF || c == clr_pkg::CH_CR) begin
							pend_d       = (c == clr_pkg::CH_CR) ? clr_pkg::PEND_CR
								: clr_pkg::PEND_LF;
							counter_d    = counter_q + 32'd1;
							prev_slash_d = 1'b0;
							status_d     = clr_pkg::ST_LINE_END;
							idx_d        = count_q;
							state_d      = (count_q == '0) ? S_TRIM : S_CHECK;
						end else if (c == clr_pkg::CH_HASH) begin
							comment_d    = 1'b1;
							prev_slash_d = 1'b0;
						end else if (comment_q) begin
							// rest of the line is comment
						end else if (c == clr_pkg::CH_SLASH) begin
							if (prev_slash_q && count_q != '0) begin
								count_d      = count_q - CW'(1);
								comment_d    = 1'b1;
								prev_slash_d = 1'b0;
							end else begin
								prev_slash_d = 1'b1;
								do_store     = 1'b1;
							end
						end else begin
							prev_slash_d = 1'b0;
							do_store     = 1'b1;
						end
					end
					if (do_store) begin
						if ({1'b0, count_q} >= FULL_AT) begin
							stopped_d = 1'b1;
							state_d   = S_ERR;
						end else begin
							wr_en   = 1'b1;
							count_d = count_q + CW'(1);
						end
					end
				end
			end
			S_CHECK: begin
				// read data holds the last stored char of the line
				if (rd_data == clr_pkg::CH_BSLASH) begin
					count_d = count_q - CW'(1);
					state_d = S_IDLE;
				end else begin
					state_d = S_TRIM;
				end
			end
			S_TRIM: begin
				if (idx_q == '0) begin
					pos_d   = '0;
					rd_addr = '0;
					state_d = S_EMIT;
				end else if (rd_data == clr_pkg::CH_SPACE || rd_data == clr_pkg::CH_TAB) begin
					idx_d   = idx_q - CW'(1);
					rd_addr = idx_q - CW'(2);
				end else begin
					pos_d   = '0;
					rd_addr = '0;
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				rd_addr = pos_q;
				beat    = '{out_char: (idx_q == '0) ? 8'h00 : rd_data,
					char_valid: (idx_q != '0), last: emit_last,
					status: status_q, line_number: counter_q};
				if (can_load) begin
					load = 1'b1;
					if (emit_last) begin
						count_d      = '0;
						comment_d    = 1'b0;
						prev_slash_d = 1'b0;
						state_d      = S_IDLE;
					end else begin
						pos_d   = pos_q + CW'(1);
						rd_addr = pos_q + CW'(1);
					end
				end
			end
			S_ERR: begin
				beat = '{out_char: 8'h00, char_valid: 1'b0, last: 1'b1,
					status: clr_pkg::ST_TOO_LONG, line_number: counter_q};
				if (can_load) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			comment_q    <= 1'b0;
			prev_slash_q <= 1'b0;
			pend_q       <= clr_pkg::PEND_NONE;
			counter_q    <= '0;
			stopped_q    <= 1'b0;
		end else begin
			state_q      <= state_d;
			count_q      <= count_d;
			comment_q    <= comment_d;
			prev_slash_q <= prev_slash_d;
			pend_q       <= pend_d;
			counter_q    <= counter_d;
			stopped_q    <= stopped_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		pos_q    <= pos_d;
		status_q <= status_d;
	end

	clr_store #(
		.DEPTH(LINE_LEN),
		.AW   (CW)
	) u_store (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (count_q),
		.wr_data  (c),
		.rd_addr  (rd_addr),
		.rd_data_q(rd_data)
	);

	clr_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.beat    (beat),
		.can_load(can_load),
		.line_out(line_out)
	);

	// a beat without a character always closes its line
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		line_out.valid |-> (line_out.char_valid || line_out.last))
		else $error("beat without character not marked last");

	// the store never fills past the overflow limit
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count_q} <= FULL_AT)
		else $error("line store count beyond limit");

	// a stopped block only sits idle or reports the overflow
	a_stopped_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> (state_q == S_IDLE || state_q == S_ERR))
		else $error("block busy while stopped");

	// the line counter moves only on an accepted beat
	a_counter_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(counter_q))
		else $error("line counter moved without an input beat");

endmodule
`default_nettype wire

FILE: tb/config_line_reader_top_tb.sv
// config_line_reader_top_tb: self-checking testbench for the config line reader.
// drives bytes and end-of-input beats, predicts every line beat and compares them.
// depends on clr_pkg, clr_in_if, clr_out_if and config_line_reader_top.
`timescale 1ns / 100ps
module config_line_reader_top_tb;

	localparam int LINE_LEN      = 64;
	localparam int IDLE_LIMIT    = 2000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 200;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	clr_in_if  stream ();
	clr_out_if lines ();

	config_line_reader_top #(.LINE_LEN(LINE_LEN)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.stream_in(stream),
		.line_out(lines)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// line assembly state of the predictor
	logic [7:0]  text_buf [LINE_LEN];
	int          text_len    = 0;
	bit          in_comment  = 1'b0;
	bit          after_slash = 1'b0;
	bit          halted      = 1'b0;
	logic [1:0]  eol_pend    = clr_pkg::PEND_NONE;
	logic [31:0] line_cnt    = 32'd0;

	clr_pkg::out_beat_t due_beats [$];
	int          errors         = 0;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	bit          hold_req       = 1'b0;
	int          hold_left      = 0;
	int          quiet_cycles   = 0;

	function automatic void queue_beat(logic [7:0] c, logic cv, logic lst, logic [1:0] st);
		clr_pkg::out_beat_t b;
		b.out_char    = c;
		b.char_valid  = cv;
		b.last        = lst;
		b.status      = st;
		b.line_number = line_cnt;
		due_beats.push_back(b);
	endfunction

	function automatic void clear_text();
		text_len    = 0;
		in_comment  = 1'b0;
		after_slash = 1'b0;
	endfunction

	function automatic void flush_text(logic [1:0] st);
		int n;
		int i;
		n = text_len;
		while (n > 0 && (text_buf[n-1] == clr_pkg::CH_SPACE ||
			text_buf[n-1] == clr_pkg::CH_TAB))
			n--;
		if (n == 0) begin
			queue_beat(8'h00, 1'b0, 1'b1, st);
		end else begin
			for (i = 0; i < n; i++)
				queue_beat(text_buf[i], 1'b1, i == n - 1, st);
		end
		clear_text();
	endfunction

	function automatic void keep_char(logic [7:0] c);
		if (text_len + 1 >= LINE_LEN - 1) begin
			queue_beat(8'h00, 1'b0, 1'b1, clr_pkg::ST_TOO_LONG);
			halted = 1'b1;
		end else begin
			text_buf[text_len] = c;
			text_len++;
		end
	endfunction

	function automatic void assemble_byte(logic [7:0] c, logic eoi);
		bit swallow;
		if (eoi) begin
			if (!halted)
				flush_text(clr_pkg::ST_END_INPUT);
			clear_text();
			eol_pend = clr_pkg::PEND_NONE;
			halted   = 1'b0;
			return;
		end
		if (halted)
			return;
		if (eol_pend != clr_pkg::PEND_NONE) begin
			// byte after a cr or lf, swallowed if it completes a cr-lf or lf-cr pair
			swallow = (eol_pend == clr_pkg::PEND_CR && c == clr_pkg::CH_LF) ||
				(eol_pend == clr_pkg::PEND_LF && c == clr_pkg::CH_CR);
			eol_pend = clr_pkg::PEND_NONE;
			if (swallow)
				return;
		end
		if (c == clr_pkg::CH_LF || c == clr_pkg::CH_CR) begin
			eol_pend = (c == clr_pkg::CH_CR) ? clr_pkg::PEND_CR : clr_pkg::PEND_LF;
			line_cnt++;
			after_slash = 1'b0;
			if (text_len == 0 || text_buf[text_len-1] != clr_pkg::CH_BSLASH)
				flush_text(clr_pkg::ST_LINE_END);
			else
				text_len--;
			return;
		end
		if (c == clr_pkg::CH_HASH) begin
			in_comment  = 1'b1;
			after_slash = 1'b0;
			return;
		end
		if (in_comment)
			return;
		if (c == clr_pkg::CH_SLASH) begin
			if (after_slash && text_len > 0) begin
				text_len--;
				in_comment  = 1'b1;
				after_slash = 1'b0;
				return;
			end
			after_slash = 1'b1;
			keep_char(c);
			return;
		end
		after_slash = 1'b0;
		keep_char(c);
	endfunction

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return 8'(8'h61 + $urandom_range(25));
		else if (r < 55)
			return clr_pkg::CH_SPACE;
		else if (r < 62)
			return clr_pkg::CH_TAB;
		else if (r < 68)
			return clr_pkg::CH_HASH;
		else if (r < 78)
			return clr_pkg::CH_SLASH;
		else if (r < 86)
			return clr_pkg::CH_BSLASH;
		return 8'($urandom_range(255));
	endfunction

	task automatic send_beat(input logic [7:0] c, input logic eoi);
		while ($urandom_range(99) < send_idle_pct) begin
			stream.valid <= 1'b0;
			@(posedge clk);
		end
		stream.valid        <= 1'b1;
		stream.in_char      <= c;
		stream.end_of_input <= eoi;
		@(posedge clk);
		while (!stream.ready)
			@(posedge clk);
		assemble_byte(c, eoi);
	endtask

	task automatic send_char(input logic [7:0] c);
		send_beat(c, 1'b0);
	endtask

	task automatic send_eoi();
		// the byte lane is don't-care on an end-of-input beat
		send_beat(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic wait_drain();
		stream.valid <= 1'b0;
		do
			@(posedge clk);
		while (due_beats.size() != 0);
	endtask

	task automatic test_line_ends();
		logic [7:0] seq [] = '{8'h00, 8'hff, clr_pkg::CH_SPACE, clr_pkg::CH_TAB,
			clr_pkg::CH_LF, clr_pkg::CH_CR, clr_pkg::CH_CR, clr_pkg::CH_LF,
			clr_pkg::CH_LF, clr_pkg::CH_LF, "a", clr_pkg::CH_BSLASH, clr_pkg::CH_CR, "b",
			clr_pkg::CH_HASH, "x", clr_pkg::CH_LF, "c", clr_pkg::CH_SLASH,
			"d", clr_pkg::CH_SLASH, clr_pkg::CH_SLASH, "e", clr_pkg::CH_LF};
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		foreach (seq[i])
			send_char(seq[i]);
		// empty final line, then a final line with content
		send_eoi();
		send_char("z");
		send_eoi();
		wait_drain();
	endtask

	task automatic test_overflow();
		int i;
		// fill to the last slot that fits, join a line, refill it, then one byte more
		for (i = 0; i < LINE_LEN - 3; i++)
			send_char(8'(8'h41 + $urandom_range(25)));
		send_char(clr_pkg::CH_BSLASH);
		send_char(clr_pkg::CH_LF);
		send_char("x");
		send_char("y");
		// ignored while stopped
		send_char(clr_pkg::CH_LF);
		send_char("q");
		send_char(clr_pkg::CH_HASH);
		send_char(clr_pkg::CH_CR);
		send_eoi();
		send_char("o");
		send_char("k");
		send_eoi();
		wait_drain();
	endtask

	task automatic test_random_lines(input int idle_pct, input int stall_pct, input int n_items);
		int sent;
		int len;
		int i;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			len = $urandom_range(0, 10);
			for (i = 0; i < len; i++)
				send_char(pick_char());
			sent += len + 1;
			case ($urandom_range(11))
				0: send_eoi();
				1, 2, 3: send_char(clr_pkg::CH_CR);
				4, 5, 6: send_char(clr_pkg::CH_LF);
				7, 8: begin
					send_char(clr_pkg::CH_CR);
					send_char(clr_pkg::CH_LF);
					sent++;
				end
				9, 10: begin
					send_char(clr_pkg::CH_LF);
					send_char(clr_pkg::CH_CR);
					sent++;
				end
				default: send_char(8'($urandom_range(255)));
			endcase
		end
		wait_drain();
	endtask

	task automatic test_backpressure();
		int i;
		int j;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b1;
		// keep offering beats while the result side is held off
		for (j = 0; j < 2; j++) begin
			for (i = 0; i < 6; i++)
				send_char(8'(8'h61 + $urandom_range(25)));
			send_char(clr_pkg::CH_CR);
		end
		wait_drain();
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			lines.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (hold_req) begin
			lines.ready <= 1'b0;
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end else begin
			lines.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		clr_pkg::out_beat_t want;
		if (lines.valid && lines.ready) begin
			if (due_beats.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, actual char %0h last %0b status %0d",
					$time, lines.out_char, lines.last, lines.status);
			end else begin
				want = due_beats.pop_front();
				check_field("out_char", 32'(want.out_char), 32'(lines.out_char));
				check_field("char_valid", 32'(want.char_valid), 32'(lines.char_valid));
				check_field("last", 32'(want.last), 32'(lines.last));
				check_field("status", 32'(want.status), 32'(lines.status));
				check_field("line_number", want.line_number, lines.line_number);
			end
		end
	end

	always @(posedge clk) begin
		if ((stream.valid && stream.ready) || (lines.valid && lines.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		stream.valid        = 1'b0;
		stream.in_char      = 8'h00;
		stream.end_of_input = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_line_ends();
		test_overflow();
		test_random_lines(0, 0, 10);
		test_random_lines(49, 0, 10);
		test_random_lines(0, 49, 10);
		test_random_lines(30, 30, 10);
		test_backpressure();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
